// ===== rtl/sfm_pkg.sv =====
// sfm_pkg: sizes, item kinds, cell link types and the saturation helper
// shared by the substring finder, its cell row and its checker.
// Depends on nothing.
package sfm_pkg;

   localparam int MAX_PATTERN     = 64;
   localparam int TEXT_COUNT_BITS = 16;

   localparam int PLEN_W  = $clog2(MAX_PATTERN + 1);
   localparam int OUT_W   = 16;
   localparam int SUM_W   = (TEXT_COUNT_BITS + 1 > OUT_W + 1) ? TEXT_COUNT_BITS + 1 : OUT_W + 1;
   localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

   localparam int REQ_DATA_W   = 8;
   localparam int REQ_USER_W   = 2;
   localparam int RSP_FIELDS_W = 1 + 4 * OUT_W + 1;
   localparam int RSP_W        = ((RSP_FIELDS_W + 7) / 8) * 8;

   // bit offsets of the result fields in rsp_tdata
   localparam int RSP_FOUND_LSB  = 0;
   localparam int RSP_POS_LSB    = 1;
   localparam int RSP_ASTART_LSB = RSP_POS_LSB + OUT_W;
   localparam int RSP_ALEN_LSB   = RSP_ASTART_LSB + OUT_W;
   localparam int RSP_TLEN_LSB   = RSP_ALEN_LSB + OUT_W;
   localparam int RSP_OVF_LSB    = RSP_TLEN_LSB + OUT_W;

   typedef enum logic [REQ_USER_W-1:0] {
      KIND_CLEAR  = 2'd0,
      KIND_APPEND = 2'd1,
      KIND_TEXT   = 2'd2,
      KIND_END    = 2'd3
   } kind_type;

   typedef struct packed {
      logic shift_text;
      logic shift_pat;
      logic clr_text;
      logic clr_pat;
   } cell_ctrl_type;

   typedef struct packed {
      logic [7:0] win;
      logic [7:0] pat;
      logic       wv;
      logic       pv;
   } cell_link_type;

   function automatic logic [OUT_W-1:0] sat_out(input logic [SUM_W-1:0] v);
      logic [OUT_W-1:0] r;
      if (v > SUM_W'(OUT_MAX)) begin
         r = OUT_MAX;
      end else begin
         r = v[OUT_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/sfm_cell.sv =====
// sfm_cell: one compare cell, holding one text window byte and one
// reversed pattern byte with their valid bits. Depends on sfm_pkg.
module sfm_cell
   import sfm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  cell_link_type prev,
   output cell_link_type cur,
   output logic          ok
);

   logic [7:0] win_ff, win_in;
   logic [7:0] pat_ff, pat_in;
   logic       wv_ff, wv_in;
   logic       pv_ff, pv_in;
   logic       eq_ff, eq_in;

   always_comb begin
      win_in = win_ff;
      pat_in = pat_ff;
      wv_in  = wv_ff;
      pv_in  = pv_ff;
      if (ctrl.shift_text) begin
         win_in = prev.win;
         wv_in  = prev.wv;
      end
      if (ctrl.shift_pat) begin
         pat_in = prev.pat;
         pv_in  = prev.pv;
      end
      if (ctrl.clr_text) begin
         wv_in = 1'b0;
      end
      if (ctrl.clr_pat) begin
         pv_in = 1'b0;
      end
      // compare the bytes this cell will hold after the edge
      eq_in = (win_in == pat_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wv_ff <= 1'b0;
         pv_ff <= 1'b0;
      end else begin
         wv_ff <= wv_in;
         pv_ff <= pv_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      pat_ff <= pat_in;
      eq_ff  <= eq_in;
   end

   assign cur = '{win: win_ff, pat: pat_ff, wv: wv_ff, pv: pv_ff};
   // a cell past the pattern end always agrees
   assign ok  = !pv_ff || (wv_ff && eq_ff);

endmodule

// ===== rtl/sfm_cell_row.sv =====
// sfm_cell_row: the chain of compare cells; text and pattern bytes enter at
// cell 0 and move one cell on with each byte. Depends on sfm_pkg, sfm_cell.
module sfm_cell_row
   import sfm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  logic [7:0]    in_byte,
   output logic          all_ok
);

   cell_link_type              link [MAX_PATTERN];
   logic [MAX_PATTERN-1:0]     ok;

   // newest byte goes to cell 0 for both the window and the reversed pattern
   assign link[0] = '{win: in_byte, pat: in_byte, wv: 1'b1, pv: 1'b1};

   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
      if (k < MAX_PATTERN - 1) begin : g_mid
         sfm_cell u_cell (
            .clock (clock),
            .reset (reset),
            .ctrl  (ctrl),
            .prev  (link[k]),
            .cur   (link[k+1]),
            .ok    (ok[k])
         );
      end else begin : g_last
         sfm_cell u_cell (
            .clock (clock),
            .reset (reset),
            .ctrl  (ctrl),
            .prev  (link[k]),
            .cur   (),
            .ok    (ok[k])
         );
      end
   end

   assign all_ok = &ok;

endmodule

// ===== rtl/substring_first_match_finder.sv =====
// The result of an end item is registered and is on rsp in the cycle after it is accepted.
// One item of any kind per cycle while req_tready is high; the window ending at
// each counted text byte is checked against the pattern by the cell chain in the
// cycle after the byte arrives. req_tready drops only while a result waits and
// rsp_tready is low. Reset clears counts, flags and valid bits, but not the
// result data register; pattern bytes are undefined until appended.
module substring_first_match_finder
   import sfm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // data_byte
   input  logic [REQ_USER_W-1:0] req_tuser,  // kind
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // found, match_position, after_start, after_length, text_length, overflow, zero pad
   output logic [RSP_W-1:0]      rsp_tdata
);

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]           rsp_data_ff, rsp_data_in;
   logic [PLEN_W-1:0]          plen_ff, plen_in;
   logic [TEXT_COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic [TEXT_COUNT_BITS-1:0] fp_ff, fp_in;
   logic                       ms_ff, ms_in;
   logic                       ovf_ff, ovf_in;
   logic                       chk_ff, chk_in;

   logic                       acc;
   kind_type                   kind;
   logic                       is_clear, is_append, is_text, is_end;
   logic                       pat_full, cnt_full;
   logic                       all_ok, hit_now, ms_eff;
   logic [TEXT_COUNT_BITS-1:0] fp_eff;
   logic                       found;
   logic [SUM_W-1:0]           pos, astart, alen, cnt_ext;
   cell_ctrl_type              ctrl;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign acc        = req_tvalid && req_tready;
   assign kind       = kind_type'(req_tuser);
   assign is_clear   = acc && (kind == KIND_CLEAR);
   assign is_append  = acc && (kind == KIND_APPEND);
   assign is_text    = acc && (kind == KIND_TEXT);
   assign is_end     = acc && (kind == KIND_END);

   assign pat_full = (plen_ff == PLEN_W'(MAX_PATTERN));
   assign cnt_full = (cnt_ff == {TEXT_COUNT_BITS{1'b1}});

   assign ctrl = '{shift_text: is_text && !cnt_full,
                   shift_pat:  is_append && !pat_full,
                   clr_text:   is_clear || is_end,
                   clr_pat:    is_clear};

   sfm_cell_row u_row (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ctrl),
      .in_byte (req_tdata),
      .all_ok  (all_ok)
   );

   // check pending from the last text byte; cell valid bits cover short text
   assign hit_now = chk_ff && all_ok && !ms_ff && (plen_ff != '0);
   assign ms_eff  = ms_ff || hit_now;
   assign fp_eff  = hit_now ? TEXT_COUNT_BITS'(SUM_W'(cnt_ff) - SUM_W'(plen_ff)) : fp_ff;

   always_comb begin
      cnt_ext = SUM_W'(cnt_ff);
      found   = ms_eff || (plen_ff == '0);
      pos     = ms_eff ? SUM_W'(fp_eff) : '0;
      astart  = found ? pos + SUM_W'(plen_ff) : '0;
      alen    = (found && (astart <= cnt_ext)) ? cnt_ext - astart : '0;
   end

   always_comb begin
      plen_in = plen_ff;
      cnt_in  = cnt_ff;
      fp_in   = fp_eff;
      ms_in   = ms_eff;
      ovf_in  = ovf_ff;
      chk_in  = 1'b0;
      if (acc) begin
         unique case (kind)
            KIND_CLEAR: begin
               plen_in = '0;
               cnt_in  = '0;
               fp_in   = '0;
               ms_in   = 1'b0;
               ovf_in  = 1'b0;
            end
            KIND_APPEND: begin
               if (pat_full) begin
                  ovf_in = 1'b1;
               end else begin
                  plen_in = plen_ff + 1'b1;
               end
            end
            KIND_TEXT: begin
               if (cnt_full) begin
                  ovf_in = 1'b1;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
                  chk_in = 1'b1;
               end
            end
            KIND_END: begin
               cnt_in = '0;
               fp_in  = '0;
               ms_in  = 1'b0;
               ovf_in = 1'b0;
            end
            default: begin
               ovf_in = ovf_ff;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (is_end) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_W'({ovf_ff, sat_out(cnt_ext), sat_out(alen),
                                sat_out(astart), sat_out(pos), found});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         plen_ff      <= '0;
         cnt_ff       <= '0;
         fp_ff        <= '0;
         ms_ff        <= 1'b0;
         ovf_ff       <= 1'b0;
         chk_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         plen_ff      <= plen_in;
         cnt_ff       <= cnt_in;
         fp_ff        <= fp_in;
         ms_ff        <= ms_in;
         ovf_ff       <= ovf_in;
         chk_ff       <= chk_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== rtl/sfm_checker.sv =====
// sfm_checker: port-level checks on the substring finder, bound to the top.
// Depends on sfm_pkg and substring_first_match_finder.
module sfm_checker
   import sfm_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_USER_W-1:0] req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_W-1:0]      rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // a new result only follows an accepted end item
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready &&
                                  (req_tuser == REQ_USER_W'(KIND_END))))
      else $error("result without end item");

   a_nofind_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[RSP_FOUND_LSB] |->
         rsp_tdata[RSP_TLEN_LSB-1:RSP_POS_LSB] == '0)
      else $error("positions set with no match");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty result register");

endmodule

bind substring_first_match_finder sfm_checker u_checker (.*);
